// ===== rtl/i2csp_pkg.sv =====
`timescale 1ns / 1ps

package i2csp_pkg;

    // Default sizes of the write request ring and of the register file
    localparam int unsigned QUEUE_DEPTH_DEF   = 16;
    localparam int unsigned REG_FILE_SIZE_DEF = 128;

    // Bus event codes as they arrive on the slave-side tuser
    localparam logic [2:0] ACT_STOP  = 3'd0;
    localparam logic [2:0] ACT_MATCH = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_POP   = 3'd4;

    // Classified operation handed from the front end to the execution unit
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_POP   = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    // One result per event
    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_address;
        logic       write_dropped;
        logic       pop_valid;
        logic [7:0] pop_address;
        logic [7:0] pop_data;
        logic [3:0] queue_count;
    } t_res;

endpackage

// ===== rtl/i2csp_front.sv =====
`timescale 1ns / 1ps

module i2csp_front
    import i2csp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data
    input  logic [2:0] s_axis_tuser,   // [2:0] action
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Classify the bus event; address match and unused codes do nothing
    always_comb begin
        w_cmd.data = s_axis_tdata;
        case (s_axis_tuser)
            ACT_STOP:  w_cmd.op = OP_STOP;
            ACT_MATCH: w_cmd.op = OP_NOP;
            ACT_WRITE: w_cmd.op = OP_WRITE;
            ACT_READ:  w_cmd.op = OP_READ;
            ACT_POP:   w_cmd.op = OP_POP;
            default:   w_cmd.op = OP_NOP;
        endcase
    end

    // Two-entry command queue toward the execution unit
    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != 2'd0);
    assign o_cmd         = r_q[r_rd];
    assign w_pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/i2csp_exec.sv =====
`timescale 1ns / 1ps

module i2csp_exec
    import i2csp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int unsigned REG_FILE_SIZE = REG_FILE_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_ready,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ready
);

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_POP = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic             r_got, n_got;
    logic [7:0]       r_base, n_base;
    logic [7:0]       r_cur, n_cur;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    logic [7:0]       r_mem_addr [QUEUE_DEPTH];
    logic [7:0]       r_mem_data [QUEUE_DEPTH];
    logic [7:0]       r_rd_addr;
    logic [7:0]       r_rd_data;

    logic [7:0]       w_wrap [256];
    logic [7:0]       w_ptr_next;
    logic             w_take;
    logic             w_push;
    logic             w_rd;
    logic             w_full;
    logic             w_empty;

    // Pointer wrap table: (p + 1) mod 256, then mod register file size
    for (genvar g = 0; g < 256; g++) begin : g_wrap
        localparam int unsigned WRAPPED = g % REG_FILE_SIZE;
        assign w_wrap[g] = 8'(WRAPPED);
    end

    assign w_ptr_next  = w_wrap[r_cur + 8'd1];
    assign w_full      = (r_count == FULL_CNT);
    assign w_empty     = (r_count == '0);
    assign o_cmd_ready = (r_state == ST_RUN) && (!r_out_valid || i_res_ready);
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Execute one command and build its result
    always_comb begin
        logic             v_load;
        t_res             v_res;
        logic [CNT_W+3:0] v_qc;

        n_state     = r_state;
        n_got       = r_got;
        n_base      = r_base;
        n_cur       = r_cur;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_push      = 1'b0;
        w_rd        = 1'b0;
        v_load      = 1'b0;
        v_res       = '0;

        case (r_state)
            ST_RUN: begin
                if (w_take) begin
                    v_load = 1'b1;
                    case (i_cmd.op)
                        OP_STOP: begin
                            n_cur = r_base;
                            n_got = 1'b0;
                        end
                        OP_WRITE: begin
                            if (!r_got) begin
                                n_got  = 1'b1;
                                n_base = i_cmd.data;
                                n_cur  = i_cmd.data;
                            end else begin
                                if (w_full) begin
                                    v_res.write_dropped = 1'b1;
                                end else begin
                                    w_push  = 1'b1;
                                    n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                                    n_count = r_count + 1'b1;
                                end
                                n_cur = w_ptr_next;
                            end
                        end
                        OP_READ: begin
                            v_res.read_valid   = 1'b1;
                            v_res.read_address = r_cur;
                            n_cur              = w_ptr_next;
                        end
                        OP_POP: begin
                            if (!w_empty) begin
                                // fetch the head entry into the read registers; ST_POP then builds the result
                                w_rd    = 1'b1;
                                n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = ST_POP;
                                v_load  = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                v_load            = 1'b1;
                v_res.pop_valid   = 1'b1;
                v_res.pop_address = r_rd_addr;
                v_res.pop_data    = r_rd_data;
                n_state           = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        v_qc              = {4'b0000, n_count};
        v_res.queue_count = v_qc[3:0];

        // Load the output register or drain it
        if (v_load) begin
            n_out_valid = 1'b1;
            n_out       = v_res;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Write request ring storage with registered read
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem_addr[r_tail] <= r_cur;
            r_mem_data[r_tail] <= i_cmd.data;
        end
        if (w_rd) begin
            r_rd_addr <= r_mem_addr[r_head];
            r_rd_data <= r_mem_data[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_got       <= 1'b0;
            r_base      <= 8'd0;
            r_cur       <= 8'd0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_got       <= n_got;
            r_base      <= n_base;
            r_cur       <= n_cur;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Ring never holds more than depth minus one requests
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("write request count beyond ring capacity");

    // A pending pop always lands in the output register next cycle
    a_pop_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_POP |=> r_out_valid && r_out.pop_valid)
        else $error("popped request not presented");

    // A dropped write leaves the ring untouched
    a_drop_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_cmd.op == OP_WRITE && r_got && w_full)
        |=> $stable(r_tail) && r_out.write_dropped)
        else $error("dropped write changed the ring");

    // Pointer is in range unless it still holds the base as written
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur} < 9'(REG_FILE_SIZE)) || (r_cur == r_base))
        else $error("register pointer out of range");

endmodule

// ===== rtl/i2c_slave_register_port_with_write_fifo.sv =====
`timescale 1ns / 1ps
// An accepted event is registered in the command queue and then in the result register;
// a pop that returns a queued request also passes through the registered ring read.
// Throughput: one event per cycle while results are taken; a pop that returns a request
// holds exec in ST_POP. A two-entry command queue decouples intake from execution.
// Reset (synchronous, active low): idle, pointers zero, ring empty, no result pending.

module i2c_slave_register_port_with_write_fifo
    import i2csp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int unsigned REG_FILE_SIZE = REG_FILE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] read_address, [15:8] pop_address,
                                        // [23:16] pop_data, [27:24] queue_count, [31:28] zero
    output logic [2:0]  m_axis_tuser    // [0] read_valid, [1] write_dropped, [2] pop_valid
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;
    t_res w_res;

    // Intake and classify bus events
    i2csp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_ready   (w_cmd_ready)
    );

    // Pointer, write ring and result register
    i2csp_exec #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .REG_FILE_SIZE (REG_FILE_SIZE)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    // Pack the result onto the master side
    assign m_axis_tdata = {4'b0000, w_res.queue_count, w_res.pop_data,
                           w_res.pop_address, w_res.read_address};
    assign m_axis_tuser = {w_res.pop_valid, w_res.write_dropped, w_res.read_valid};

endmodule
